### src/astpm_pkg.sv
// astpm_pkg: shared types and constants for the analog stick pointer block
// no dependencies; imported by every module of the block
`default_nettype none

package astpm_pkg;

  // full-scale stick deflection used by the dead-zone rescale
  localparam logic [16:0] FULL_SCALE      = 17'd32768;
  // largest whole-pixel step in either direction
  localparam logic [5:0]  STEP_LIMIT      = 6'd32;
  // dead zone after reset
  localparam logic [14:0] DEAD_ZONE_RESET = 15'd3000;

  // configuration port
  localparam int unsigned PADDR_W       = 3;
  localparam logic [0:0]  REG_DEAD_ZONE = 1'b0;

  // last count of each serial unit
  localparam logic [3:0] MUL_LAST  = 4'd15;
  localparam logic [3:0] SQRT_LAST = 4'd15;
  localparam logic [4:0] DIV_LAST  = 5'd28;

  // status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_GATE,
    ST_NUM,
    ST_DEN,
    ST_DIV,
    ST_SUM,
    ST_SPLIT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### src/astpm_mul.sv
// astpm_mul: 16 x 16 unsigned shift-and-add multiplier, one multiplier bit per cycle
// depends on astpm_pkg (unit_stat_t, MUL_LAST)
`default_nettype none

module astpm_mul
  import astpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic [31:0]      prod,
  output unit_stat_t       stat
);

  logic [15:0] mcand;
  logic [31:0] acc;
  logic [3:0]  cnt;
  logic        busy;
  logic [16:0] upper_next;

  // add the multiplicand when the low bit of the multiplier is set
  assign upper_next = {1'b0, acc[31:16]} + (acc[0] ? {1'b0, mcand} : 17'd0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == MUL_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: product shifts right, multiplier bits leave at the bottom
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand <= a;
      acc   <= {16'd0, b};
    end else if (busy) begin
      acc <= {upper_next, acc[15:1]};
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == MUL_LAST);

endmodule

`default_nettype wire

### src/astpm_sqrt.sv
// astpm_sqrt: 32-bit integer square root, two radicand bits per cycle
// depends on astpm_pkg (unit_stat_t, SQRT_LAST)
`default_nettype none

module astpm_sqrt
  import astpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic [15:0]      root,
  output unit_stat_t       stat
);

  logic [31:0] src;
  logic [17:0] rem;
  logic [15:0] root_r;
  logic [3:0]  cnt;
  logic        busy;
  logic [19:0] cur;
  logic [19:0] trial;
  logic [19:0] diff;
  logic        fits;

  // bring down the next bit pair and try the next root bit
  assign cur   = {rem, src[31:30]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = cur - trial;
  assign fits  = (cur >= trial);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 4'd1;
      if (cnt == SQRT_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      src    <= radicand;
      rem    <= '0;
      root_r <= '0;
    end else if (busy) begin
      src    <= {src[29:0], 2'b00};
      rem    <= fits ? diff[17:0] : cur[17:0];
      root_r <= {root_r[14:0], fits};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == SQRT_LAST);

endmodule

`default_nettype wire

### src/astpm_div.sv
// astpm_div: restoring divider for (num * 32768) / den, one quotient bit per cycle
// quotient is known to fit 29 bits; depends on astpm_pkg (unit_stat_t, DIV_LAST)
`default_nettype none

module astpm_div
  import astpm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic [28:0]      quo,
  output unit_stat_t       stat
);

  logic [31:0] rem;
  logic [31:0] den_r;
  logic [28:0] qd;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] cur;
  logic [32:0] diff;
  logic        fits;

  // shift in the next dividend bit and compare against the divisor
  assign cur  = {rem, qd[28]};
  assign diff = cur - {1'b0, den_r};
  assign fits = (cur >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start && !busy) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == DIV_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath: top dividend bits preload the remainder, the rest shift through qd
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      den_r <= den;
      rem   <= {14'd0, num[31:14]};
      qd    <= {num[13:0], 15'd0};
    end else if (busy) begin
      rem <= fits ? diff[31:0] : cur[31:0];
      qd  <= {qd[27:0], fits};
    end
  end

  assign quo       = qd;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == DIV_LAST);

endmodule

`default_nettype wire

### src/analog_stick_to_pointer_motion.sv
// analog_stick_to_pointer_motion: radial scaled dead zone, sub-pixel accumulation
// and saturated pointer update; uses astpm_pkg, astpm_mul, astpm_sqrt, astpm_div
// an item runs through the bit-serial multipliers, square root and dividers one
//   after another; inside the dead zone the numerator, denominator and divide
//   steps are skipped
// one item is in flight at a time: a new item is taken only in the idle state
// reset: dead_zone returns to 3000, residuals clear, no result pending
`default_nettype none

module analog_stick_to_pointer_motion
  import astpm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] stick_x,
  input  wire logic signed [15:0] stick_y,
  input  wire logic signed [15:0] pointer_x,
  input  wire logic signed [15:0] pointer_y,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      new_x,
  output logic signed [15:0]      new_y,
  output logic signed [6:0]       step_x,
  output logic signed [6:0]       step_y
);

  localparam logic [15:0] POS_MAX = 16'h7fff;
  localparam logic [15:0] POS_MIN = 16'h8000;

  state_t state, state_next;

  // configuration and persistent state
  logic [14:0] dead_zone;
  logic [11:0] residual_x, residual_y;

  // captured item
  logic [15:0] abs_x, abs_y;
  logic        neg_x, neg_y;
  logic [15:0] ptr_x, ptr_y;

  // intermediate values
  logic        live;
  logic [31:0] num_x;
  logic [30:0] sum_x, sum_y;
  logic [29:0] mag_x, mag_y;
  logic        sgn_x, sgn_y;

  // output register
  logic [15:0] new_x_r, new_y_r;
  logic [6:0]  step_x_r, step_y_r;
  logic        out_valid_r;
  logic        out_free;

  // unit connections
  logic        mul0_start, mul1_start, sqrt_start, div_start;
  logic [15:0] mul0_a, mul0_b, mul1_a, mul1_b;
  logic [31:0] prod0, prod1;
  logic [15:0] root;
  logic [28:0] quo0, quo1;
  unit_stat_t  mul0_stat, mul1_stat, sqrt_stat, div0_stat, div1_stat;

  // derived values
  logic [15:0] diff;
  logic [15:0] span;
  logic [16:0] span_full;
  logic        outside;
  logic [30:0] q_ext_x, q_ext_y;
  logic [30:0] res_ext_x, res_ext_y;
  logic [30:0] neg_sum_x, neg_sum_y;
  logic [18:0] qm_x, qm_y;
  logic [11:0] rm_x, rm_y;
  logic [11:0] res_new_x, res_new_y;
  logic [5:0]  stm_x, stm_y;
  logic [6:0]  step_new_x, step_new_y;
  logic [16:0] pos_x, pos_y;
  logic [15:0] new_x_v, new_y_v;
  logic        moved;

  // apb register access
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2:2] == REG_DEAD_ZONE) begin
      prdata = {17'd0, dead_zone};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= DEAD_ZONE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2:2] == REG_DEAD_ZONE)) begin
      dead_zone <= pwdata[14:0];
    end
  end

  // serial arithmetic units
  astpm_mul u_mul0 (
    .clk   (clk),
    .rst   (rst),
    .start (mul0_start),
    .a     (mul0_a),
    .b     (mul0_b),
    .prod  (prod0),
    .stat  (mul0_stat)
  );

  astpm_mul u_mul1 (
    .clk   (clk),
    .rst   (rst),
    .start (mul1_start),
    .a     (mul1_a),
    .b     (mul1_b),
    .prod  (prod1),
    .stat  (mul1_stat)
  );

  astpm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (prod0 + prod1),
    .root     (root),
    .stat     (sqrt_stat)
  );

  astpm_div u_div0 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_x),
    .den   (prod0),
    .quo   (quo0),
    .stat  (div0_stat)
  );

  astpm_div u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod1),
    .den   (prod0),
    .quo   (quo1),
    .stat  (div1_stat)
  );

  // dead-zone terms
  assign diff      = root - {1'b0, dead_zone};
  assign span_full = FULL_SCALE - {2'b00, dead_zone};
  assign span      = span_full[15:0];
  assign outside   = (root >= {1'b0, dead_zone}) && (root != 16'd0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SQUARE;
      ST_SQUARE: if (mul0_stat.done && mul1_stat.done) state_next = ST_ROOT;
      ST_ROOT:   if (sqrt_stat.done) state_next = ST_GATE;
      ST_GATE:   state_next = outside ? ST_NUM : ST_SUM;
      ST_NUM:    if (mul0_stat.done) state_next = ST_DEN;
      ST_DEN:    if (mul0_stat.done) state_next = ST_DIV;
      ST_DIV:    if (div0_stat.done && div1_stat.done) state_next = ST_SUM;
      ST_SUM:    state_next = ST_SPLIT;
      ST_SPLIT:  state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: unit starts and operand selection
  always_comb begin
    in_ready   = 1'b0;
    mul0_start = 1'b0;
    mul1_start = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul0_a     = abs_x;
    mul0_b     = abs_x;
    mul1_a     = abs_y;
    mul1_b     = abs_y;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SQUARE: begin
        mul0_start = 1'b1;
        mul1_start = 1'b1;
      end
      ST_ROOT: begin
        sqrt_start = 1'b1;
      end
      ST_NUM: begin
        mul0_start = 1'b1;
        mul1_start = 1'b1;
        mul0_b     = diff;
        mul1_b     = diff;
      end
      ST_DEN: begin
        mul0_start = 1'b1;
        mul0_a     = root;
        mul0_b     = span;
      end
      ST_DIV: begin
        div_start = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // accumulate into residuals
  assign q_ext_x   = live ? {2'b00, quo0} : 31'd0;
  assign q_ext_y   = live ? {2'b00, quo1} : 31'd0;
  assign res_ext_x = {{19{residual_x[11]}}, residual_x};
  assign res_ext_y = {{19{residual_y[11]}}, residual_y};
  assign neg_sum_x = -sum_x;
  assign neg_sum_y = -sum_y;

  // split into whole pixels and remainder, truncating toward zero; clamp the step and move the pointer
  always_comb begin
    qm_x       = mag_x[29:11];
    qm_y       = mag_y[29:11];
    rm_x       = {1'b0, mag_x[10:0]};
    rm_y       = {1'b0, mag_y[10:0]};
    res_new_x  = sgn_x ? -rm_x : rm_x;
    res_new_y  = sgn_y ? -rm_y : rm_y;
    stm_x      = (qm_x > {13'd0, STEP_LIMIT}) ? STEP_LIMIT : qm_x[5:0];
    stm_y      = (qm_y > {13'd0, STEP_LIMIT}) ? STEP_LIMIT : qm_y[5:0];
    step_new_x = sgn_x ? -{1'b0, stm_x} : {1'b0, stm_x};
    step_new_y = sgn_y ? -{1'b0, stm_y} : {1'b0, stm_y};
    pos_x      = {ptr_x[15], ptr_x} + {{10{step_new_x[6]}}, step_new_x};
    pos_y      = {ptr_y[15], ptr_y} + {{10{step_new_y[6]}}, step_new_y};
    new_x_v    = pos_x[15:0];
    new_y_v    = pos_y[15:0];
    // saturate the pointer to 16-bit signed
    if (pos_x[16] != pos_x[15]) begin
      new_x_v = pos_x[16] ? POS_MIN : POS_MAX;
    end
    if (pos_y[16] != pos_y[15]) begin
      new_y_v = pos_y[16] ? POS_MIN : POS_MAX;
    end
    moved = (qm_x != 19'd0) || (qm_y != 19'd0);
  end

  assign out_free = !out_valid_r || out_ready;

  // item datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      abs_x <= stick_x[15] ? -stick_x : stick_x;
      abs_y <= stick_y[15] ? -stick_y : stick_y;
      neg_x <= stick_x[15];
      neg_y <= stick_y[15];
      ptr_x <= pointer_x;
      ptr_y <= pointer_y;
    end
    if (state == ST_GATE) begin
      live <= outside;
    end
    // keep the x numerator before the shared multiplier takes the denominator
    if (state == ST_DEN && !mul0_stat.busy) begin
      num_x <= prod0;
    end
    if (state == ST_SUM) begin
      sum_x <= neg_x ? (res_ext_x - q_ext_x) : (res_ext_x + q_ext_x);
      sum_y <= neg_y ? (res_ext_y - q_ext_y) : (res_ext_y + q_ext_y);
    end
    if (state == ST_SPLIT) begin
      sgn_x <= sum_x[30];
      sgn_y <= sum_y[30];
      mag_x <= sum_x[30] ? neg_sum_x[29:0] : sum_x[29:0];
      mag_y <= sum_y[30] ? neg_sum_y[29:0] : sum_y[29:0];
    end
  end

  // residual state
  always_ff @(posedge clk) begin
    if (rst) begin
      residual_x <= '0;
      residual_y <= '0;
    end else if (state == ST_DONE && out_free) begin
      residual_x <= res_new_x;
      residual_y <= res_new_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (state == ST_DONE && out_free && moved) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free && moved) begin
      new_x_r  <= new_x_v;
      new_y_r  <= new_y_v;
      step_x_r <= step_new_x;
      step_y_r <= step_new_y;
    end
  end

  assign out_valid = out_valid_r;
  assign new_x     = new_x_r;
  assign new_y     = new_y_r;
  assign step_x    = step_x_r;
  assign step_y    = step_y_r;

endmodule

`default_nettype wire
